/* rtl/plm_pkg.sv */
package plm_pkg;

  // Pool geometry. Index NODE_COUNT stands for null.
  localparam int NODE_COUNT = 64;
  localparam int IDX_W      = 7;
  localparam int ADDR_W     = $clog2(NODE_COUNT);
  localparam int OP_W       = 3;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam idx_t  NULL_IDX  = idx_t'(NODE_COUNT);
  localparam addr_t LAST_ADDR = addr_t'(NODE_COUNT - 1);

  // One node word: free mark and next link.
  typedef struct packed {
    logic free;
    idx_t link;
  } node_t;

  localparam node_t NODE_RESET = '{free: 1'b1, link: NULL_IDX};

  typedef enum logic [OP_W-1:0] {
    OP_INIT   = 3'd0,
    OP_ALLOC  = 3'd1,
    OP_REMOVE = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_APPEND = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_RM_HEAD,
    ST_RM_WALK,
    ST_RM_ELEM,
    ST_RM_FREE,
    ST_CLEAR,
    ST_APP_WALK,
    ST_APP_ELEM,
    ST_DONE
  } state_e;

  // Request from the sequencer to the node store.
  typedef struct packed {
    logic  clr;
    logic  we;
    addr_t wr_addr;
    node_t wr_data;
    addr_t rd_addr;
  } ram_req_t;

  // Finished result handed to the output register.
  typedef struct packed {
    logic done;
    idx_t result_index;
    logic walk_limit_hit;
  } result_t;

endpackage

/* rtl/plm_node_store.sv */
module plm_node_store (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  plm_pkg::ram_req_t req_i,
  output plm_pkg::node_t    rd_data_o
);

  plm_pkg::node_t mem_q [plm_pkg::NODE_COUNT];
  plm_pkg::node_t rd_mem_q;
  plm_pkg::node_t fwd_data_q;
  logic           fwd_q;
  logic           rd_vld_q;
  logic [plm_pkg::NODE_COUNT-1:0] vld_q;
  logic           hit;

  // A read of the address being written returns the new word.
  assign hit = req_i.we && (req_i.wr_addr == req_i.rd_addr);

  // Node words: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    rd_mem_q   <= mem_q[req_i.rd_addr];
    fwd_data_q <= req_i.wr_data;
  end

  // Valid bits. An entry not written since reset or init reads as a free null node.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      fwd_q    <= hit;
      rd_vld_q <= vld_q[req_i.rd_addr];
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.we) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data_o = fwd_q    ? fwd_data_q :
                     rd_vld_q ? rd_mem_q   : plm_pkg::NODE_RESET;

endmodule

/* rtl/plm_ctrl.sv */
module plm_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [plm_pkg::OP_W-1:0]  op_i,
  input  plm_pkg::idx_t             head_i,
  input  plm_pkg::idx_t             elem_i,
  input  logic                      res_ready_i,
  input  plm_pkg::node_t            rd_data_i,
  output logic                      busy_o,
  output plm_pkg::ram_req_t         ram_req_o,
  output plm_pkg::result_t          result_o
);

  plm_pkg::state_e state_q, state_d;
  plm_pkg::addr_t  cnt_q, cnt_d;
  plm_pkg::addr_t  addr_q;
  plm_pkg::addr_t  prev_addr_q, prev_addr_d;
  logic            prev_free_q, prev_free_d;
  plm_pkg::idx_t   head_q, head_d;
  plm_pkg::idx_t   elem_q, elem_d;
  plm_pkg::idx_t   res_q, res_d;
  logic            lim_q, lim_d;

  plm_pkg::idx_t   head_n, elem_n;
  plm_pkg::idx_t   rd_link;
  logic            link_null, link_is_e, cnt_last, addr_last;
  plm_pkg::op_e    op;

  // Out-of-range indexes count as null.
  assign head_n = (head_i >= plm_pkg::NULL_IDX) ? plm_pkg::NULL_IDX : head_i;
  assign elem_n = (elem_i >= plm_pkg::NULL_IDX) ? plm_pkg::NULL_IDX : elem_i;
  assign op     = plm_pkg::op_e'(op_i);

  // Shared compare unit on the word read in the previous cycle.
  assign rd_link   = rd_data_i.link;
  assign link_null = (rd_link == plm_pkg::NULL_IDX);
  assign link_is_e = (rd_link == elem_q);
  assign cnt_last  = (cnt_q == plm_pkg::LAST_ADDR);
  assign addr_last = (addr_q == plm_pkg::LAST_ADDR);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      plm_pkg::ST_IDLE: begin
        if (start_i) begin
          unique case (op)
            plm_pkg::OP_ALLOC: state_d = plm_pkg::ST_ALLOC;
            plm_pkg::OP_REMOVE: begin
              if (head_n == plm_pkg::NULL_IDX || elem_n == plm_pkg::NULL_IDX) begin
                state_d = plm_pkg::ST_DONE;
              end else if (head_n == elem_n) begin
                state_d = plm_pkg::ST_RM_HEAD;
              end else begin
                state_d = plm_pkg::ST_RM_WALK;
              end
            end
            plm_pkg::OP_CLEAR: begin
              state_d = (head_n == plm_pkg::NULL_IDX) ? plm_pkg::ST_DONE : plm_pkg::ST_CLEAR;
            end
            plm_pkg::OP_APPEND: begin
              state_d = (head_n == plm_pkg::NULL_IDX) ? plm_pkg::ST_DONE
                                                      : plm_pkg::ST_APP_WALK;
            end
            default: state_d = plm_pkg::ST_DONE;
          endcase
        end
      end
      plm_pkg::ST_ALLOC: begin
        if (rd_data_i.free || addr_last) state_d = plm_pkg::ST_DONE;
      end
      plm_pkg::ST_RM_HEAD: state_d = plm_pkg::ST_DONE;
      plm_pkg::ST_RM_WALK: begin
        if (link_is_e) begin
          state_d = plm_pkg::ST_RM_ELEM;
        end else if (link_null || cnt_last) begin
          state_d = plm_pkg::ST_DONE;
        end
      end
      plm_pkg::ST_RM_ELEM: state_d = plm_pkg::ST_RM_FREE;
      plm_pkg::ST_RM_FREE: state_d = plm_pkg::ST_DONE;
      plm_pkg::ST_CLEAR: begin
        if (link_null || cnt_last) state_d = plm_pkg::ST_DONE;
      end
      plm_pkg::ST_APP_WALK: begin
        if (link_null) begin
          state_d = (elem_q == plm_pkg::NULL_IDX) ? plm_pkg::ST_DONE : plm_pkg::ST_APP_ELEM;
        end else if (cnt_last) begin
          state_d = plm_pkg::ST_DONE;
        end
      end
      plm_pkg::ST_APP_ELEM: state_d = plm_pkg::ST_DONE;
      plm_pkg::ST_DONE: begin
        if (res_ready_i) state_d = plm_pkg::ST_IDLE;
      end
      default: state_d = plm_pkg::ST_IDLE;
    endcase
  end

  // Memory requests and datapath updates.
  always_comb begin
    ram_req_o   = '0;
    cnt_d       = cnt_q + 1'b1;
    prev_addr_d = prev_addr_q;
    prev_free_d = prev_free_q;
    head_d      = head_q;
    elem_d      = elem_q;
    res_d       = res_q;
    lim_d       = lim_q;
    unique case (state_q)
      plm_pkg::ST_IDLE: begin
        if (start_i) begin
          head_d = head_n;
          elem_d = elem_n;
          res_d  = plm_pkg::NULL_IDX;
          lim_d  = 1'b0;
          cnt_d  = '0;
          unique case (op)
            plm_pkg::OP_INIT: ram_req_o.clr = 1'b1;
            plm_pkg::OP_ALLOC: ram_req_o.rd_addr = '0;
            plm_pkg::OP_REMOVE: begin
              if (head_n != plm_pkg::NULL_IDX && elem_n == plm_pkg::NULL_IDX) begin
                res_d = head_n;
              end
              ram_req_o.rd_addr = head_n[plm_pkg::ADDR_W-1:0];
            end
            plm_pkg::OP_CLEAR: ram_req_o.rd_addr = head_n[plm_pkg::ADDR_W-1:0];
            plm_pkg::OP_APPEND: begin
              if (head_n == plm_pkg::NULL_IDX) res_d = elem_n;
              ram_req_o.rd_addr = head_n[plm_pkg::ADDR_W-1:0];
            end
            default: ;
          endcase
        end
      end
      // Scan for the lowest free node, one word a cycle.
      plm_pkg::ST_ALLOC: begin
        if (rd_data_i.free) begin
          ram_req_o.we      = 1'b1;
          ram_req_o.wr_addr = addr_q;
          ram_req_o.wr_data = '{free: 1'b0, link: plm_pkg::NULL_IDX};
          res_d             = plm_pkg::idx_t'(addr_q);
        end else if (!addr_last) begin
          ram_req_o.rd_addr = addr_q + 1'b1;
        end
      end
      // Removing the head frees it and keeps its link.
      plm_pkg::ST_RM_HEAD: begin
        ram_req_o.we      = 1'b1;
        ram_req_o.wr_addr = addr_q;
        ram_req_o.wr_data = '{free: 1'b1, link: rd_link};
        res_d             = rd_link;
      end
      plm_pkg::ST_RM_WALK: begin
        if (link_is_e) begin
          prev_addr_d       = addr_q;
          prev_free_d       = rd_data_i.free;
          ram_req_o.rd_addr = elem_q[plm_pkg::ADDR_W-1:0];
        end else if (link_null) begin
          res_d = head_q;
        end else if (cnt_last) begin
          res_d = head_q;
          lim_d = 1'b1;
        end else begin
          ram_req_o.rd_addr = rd_link[plm_pkg::ADDR_W-1:0];
        end
      end
      // Predecessor takes the element's link.
      plm_pkg::ST_RM_ELEM: begin
        ram_req_o.we      = 1'b1;
        ram_req_o.wr_addr = prev_addr_q;
        ram_req_o.wr_data = '{free: prev_free_q, link: rd_link};
      end
      plm_pkg::ST_RM_FREE: begin
        ram_req_o.we      = 1'b1;
        ram_req_o.wr_addr = elem_q[plm_pkg::ADDR_W-1:0];
        ram_req_o.wr_data = plm_pkg::NODE_RESET;
        res_d             = head_q;
      end
      // Free the current node while the next one is read.
      plm_pkg::ST_CLEAR: begin
        ram_req_o.we      = 1'b1;
        ram_req_o.wr_addr = addr_q;
        ram_req_o.wr_data = plm_pkg::NODE_RESET;
        if (!link_null) begin
          if (cnt_last) begin
            lim_d = 1'b1;
          end else begin
            ram_req_o.rd_addr = rd_link[plm_pkg::ADDR_W-1:0];
          end
        end
      end
      plm_pkg::ST_APP_WALK: begin
        if (link_null) begin
          ram_req_o.we      = 1'b1;
          ram_req_o.wr_addr = addr_q;
          ram_req_o.wr_data = '{free: rd_data_i.free, link: elem_q};
          ram_req_o.rd_addr = elem_q[plm_pkg::ADDR_W-1:0];
          res_d             = head_q;
        end else if (cnt_last) begin
          res_d = head_q;
          lim_d = 1'b1;
        end else begin
          ram_req_o.rd_addr = rd_link[plm_pkg::ADDR_W-1:0];
        end
      end
      // The appended element gets a null link and keeps its free mark.
      plm_pkg::ST_APP_ELEM: begin
        ram_req_o.we      = 1'b1;
        ram_req_o.wr_addr = elem_q[plm_pkg::ADDR_W-1:0];
        ram_req_o.wr_data = '{free: rd_data_i.free, link: plm_pkg::NULL_IDX};
      end
      plm_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    cnt_q       <= cnt_d;
    addr_q      <= ram_req_o.rd_addr;
    prev_addr_q <= prev_addr_d;
    prev_free_q <= prev_free_d;
    head_q      <= head_d;
    elem_q      <= elem_d;
    res_q       <= res_d;
    lim_q       <= lim_d;
  end

  assign busy_o                  = (state_q != plm_pkg::ST_IDLE);
  assign result_o.done           = (state_q == plm_pkg::ST_DONE);
  assign result_o.result_index   = res_q;
  assign result_o.walk_limit_hit = lim_q;

endmodule

/* rtl/pooled_linked_list_manager.sv */
// Channel | Handshake                 | Payload
// input   | in_valid_i / in_stall_o   | op_i, list_head_i, element_i
// output  | out_valid_o / out_stall_i | result_index_o, walk_limit_hit_o
//
// Init and unused op codes go from idle straight to the done state.
// Alloc scans one node a cycle and clear follows one link a cycle; append and remove
// walk the list as well.
// The next item can be accepted once the result register has loaded. While
// that register is full and stalled, the finished result waits in the sequencer.
// Reset and init clear the per-node valid bits at once; no sweep.
module pooled_linked_list_manager (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [plm_pkg::OP_W-1:0]    op_i,
  input  logic [plm_pkg::IDX_W-1:0]   list_head_i,
  input  logic [plm_pkg::IDX_W-1:0]   element_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [plm_pkg::IDX_W-1:0]   result_index_o,
  output logic                        walk_limit_hit_o
);

  logic              busy;
  logic              accept;
  logic              res_ready;
  logic              out_valid_q;
  plm_pkg::idx_t     out_index_q;
  logic              out_lim_q;
  plm_pkg::ram_req_t ram_req;
  plm_pkg::node_t    rd_data;
  plm_pkg::result_t  result;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;
  assign res_ready  = !out_valid_q || !out_stall_i;

  plm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .op_i       (op_i),
    .head_i     (list_head_i),
    .elem_i     (element_i),
    .res_ready_i(res_ready),
    .rd_data_i  (rd_data),
    .busy_o     (busy),
    .ram_req_o  (ram_req),
    .result_o   (result)
  );

  plm_node_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (ram_req),
    .rd_data_o(rd_data)
  );

  // Output register: loads a finished result when empty or being drained.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (result.done && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result.done && res_ready) begin
      out_index_q <= result.result_index;
      out_lim_q   <= result.walk_limit_hit;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_index_o   = out_index_q;
  assign walk_limit_hit_o = out_lim_q;

endmodule

/* rtl/plm_checker.sv */
module plm_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [plm_pkg::IDX_W-1:0] result_index_o,
  input logic                      walk_limit_hit_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(result_index_o) && $stable(walk_limit_hit_o))
    else $error("stalled result changed");

  // Once an item is taken, the block is busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // A new result only appears while an item is in work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without an item in work");

  // Reset empties the output register by the next edge.
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid after reset");

endmodule

bind pooled_linked_list_manager plm_checker u_checker (.*);

/* dv/pooled_linked_list_manager_test.sv */
module pooled_linked_list_manager_test;
  import plm_pkg::*;

  // Copies of the pool state: one steers stimulus generation, one checks the block.
  localparam int GEN_POOL = 0;
  localparam int CHK_POOL = 1;
  localparam int LISTS = 3;
  localparam int RANDOM_ITEMS = 1650;
  localparam int QUIET_FIRST = 600;
  localparam int QUIET_LAST = 950;
  localparam int IDLE_PERCENT = 14;
  localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_LAST = 3'd7;
  localparam idx_t IDX_MAX = '1;

  typedef struct packed {
    logic [OP_W-1:0] op;
    idx_t            head;
    idx_t            element;
  } request_t;

  typedef struct packed {
    idx_t index;
    logic limit;
  } outcome_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic [OP_W-1:0] op_i = '0;
  idx_t            list_head_i = '0;
  idx_t            element_i = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  idx_t            result_index_o;
  logic            walk_limit_hit_o;

  logic     free_mark [2][NODE_COUNT];
  idx_t     next_link [2][NODE_COUNT];
  request_t pending_requests [$];
  outcome_t expected_results [$];
  request_t next_req;
  outcome_t want;
  int       accepted_items = 0;
  int       checked_results = 0;
  int       error_count = 0;

  pooled_linked_list_manager u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .list_head_i      (list_head_i),
    .element_i        (element_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_index_o   (result_index_o),
    .walk_limit_hit_o (walk_limit_hit_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Any index at or above the pool size stands for null.
  function automatic idx_t to_index(idx_t raw);
    return (raw >= NULL_IDX) ? NULL_IDX : raw;
  endfunction

  function automatic void pool_init(int p);
    for (int i = 0; i < NODE_COUNT; i++) begin
      free_mark[p][i] = 1'b1;
      next_link[p][i] = NULL_IDX;
    end
  endfunction

  // Applies one operation to pool copy p and returns the result item.
  // Every operation keeps the link graph free of cycles, so the walk limit
  // flag is expected low throughout; it is still checked on every result.
  function automatic outcome_t pool_step(int p, logic [OP_W-1:0] op, idx_t head_raw,
                                         idx_t elem_raw);
    idx_t     head;
    idx_t     elem;
    idx_t     cur;
    idx_t     nxt;
    logic     walking;
    int       i;
    outcome_t res;
    head = to_index(head_raw);
    elem = to_index(elem_raw);
    res = '{index: NULL_IDX, limit: 1'b0};
    case (op)
      OP_INIT: pool_init(p);
      OP_ALLOC: begin
        walking = 1'b1;
        for (i = 0; i < NODE_COUNT && walking; i++) begin
          if (free_mark[p][i]) begin
            free_mark[p][i] = 1'b0;
            next_link[p][i] = NULL_IDX;
            res.index = idx_t'(i);
            walking = 1'b0;
          end
        end
      end
      OP_REMOVE: begin
        if (head == NULL_IDX) begin
          res.index = NULL_IDX;
        end else if (elem == NULL_IDX) begin
          res.index = head;
        end else if (head == elem) begin
          // The head leaves the list but keeps its own link.
          free_mark[p][elem] = 1'b1;
          res.index = next_link[p][head];
        end else begin
          res.index = head;
          cur = head;
          walking = 1'b1;
          for (i = 0; i < NODE_COUNT && walking; i++) begin
            if (cur == NULL_IDX) begin
              walking = 1'b0;
            end else if (next_link[p][cur] == elem) begin
              next_link[p][cur] = next_link[p][elem];
              next_link[p][elem] = NULL_IDX;
              free_mark[p][elem] = 1'b1;
              walking = 1'b0;
            end else begin
              cur = next_link[p][cur];
            end
          end
          if (walking && cur != NULL_IDX) res.limit = 1'b1;
        end
      end
      OP_CLEAR: begin
        cur = head;
        walking = 1'b1;
        for (i = 0; i < NODE_COUNT && walking; i++) begin
          if (cur == NULL_IDX) begin
            walking = 1'b0;
          end else begin
            nxt = next_link[p][cur];
            free_mark[p][cur] = 1'b1;
            next_link[p][cur] = NULL_IDX;
            cur = nxt;
          end
        end
        if (walking && cur != NULL_IDX) res.limit = 1'b1;
      end
      OP_APPEND: begin
        if (head == NULL_IDX) begin
          res.index = elem;
        end else begin
          res.index = head;
          cur = head;
          for (i = 1; i < NODE_COUNT && next_link[p][cur] != NULL_IDX; i++) begin
            cur = next_link[p][cur];
          end
          if (next_link[p][cur] != NULL_IDX) begin
            res.limit = 1'b1;
          end else begin
            next_link[p][cur] = elem;
            if (elem != NULL_IDX) next_link[p][elem] = NULL_IDX;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic idx_t rand_idx();
    return idx_t'($urandom_range(0, IDX_MAX));
  endfunction

  function automatic int list_length(idx_t head);
    idx_t cur;
    int   n;
    cur = head;
    n = 0;
    while (cur < NULL_IDX && n < NODE_COUNT) begin
      cur = next_link[GEN_POOL][cur];
      n++;
    end
    return n;
  endfunction

  function automatic idx_t member_at(idx_t head, int pos);
    idx_t cur;
    cur = head;
    for (int i = 0; i < pos && cur < NULL_IDX; i++) cur = next_link[GEN_POOL][cur];
    return cur;
  endfunction

  // Queues one item and tracks its effect on the generation copy of the pool.
  task automatic queue_request(input logic [OP_W-1:0] op, input idx_t head, input idx_t elem,
                               output outcome_t res);
    request_t req;
    req = '{op: op, head: head, element: elem};
    res = pool_step(GEN_POOL, op, head, elem);
    pending_requests.push_back(req);
  endtask

  function automatic bit take_break(int count);
    return (count < QUIET_FIRST || count >= QUIET_LAST) &&
           ($urandom_range(0, 99) < IDLE_PERCENT);
  endfunction

  task automatic report_mismatch(string what, int got, int exp_val);
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, exp_val);
    error_count++;
  endtask

  // Request driver: predicts each accepted item and presents the next one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      op_i <= '0;
      list_head_i <= '0;
      element_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(pool_step(CHK_POOL, op_i, list_head_i, element_i));
        accepted_items++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_requests.size() != 0 && !take_break(accepted_items)) begin
          next_req = pending_requests.pop_front();
          in_valid_i <= 1'b1;
          op_i <= next_req.op;
          list_head_i <= next_req.head;
          element_i <= next_req.element;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each taken result with the oldest prediction and stalls the output at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result_index", result_index_o, -1);
        end else begin
          want = expected_results.pop_front();
          if (result_index_o !== want.index)
            report_mismatch("result_index", result_index_o, want.index);
          if (walk_limit_hit_o !== want.limit)
            report_mismatch("walk_limit_hit", walk_limit_hit_o, want.limit);
        end
        checked_results++;
      end
      out_stall_i <= take_break(checked_results);
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin
    #15000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    outcome_t res;
    idx_t     list_heads [LISTS];
    idx_t     fresh;
    idx_t     head;
    idx_t     elem;
    int       k;
    int       roll;
    int       len;
    int       pick;
    bit       growing;
    pool_init(GEN_POOL);
    pool_init(CHK_POOL);

    // Directed part: build 0 -> 1 -> 2, then walk through the corner cases.
    queue_request(OP_ALLOC, '0, IDX_MAX, res);
    queue_request(OP_ALLOC, IDX_MAX, '0, res);
    queue_request(OP_ALLOC, rand_idx(), rand_idx(), res);
    queue_request(OP_APPEND, 7'd0, 7'd1, res);
    queue_request(OP_APPEND, 7'd0, 7'd2, res);
    // Null element on append, then appends to an empty list.
    queue_request(OP_APPEND, 7'd0, IDX_MAX, res);
    queue_request(OP_APPEND, NULL_IDX, 7'd5, res);
    queue_request(OP_APPEND, 7'd100, NULL_IDX, res);
    // Remove from an empty list, with null elements, and with a stranger.
    queue_request(OP_REMOVE, NULL_IDX, 7'd1, res);
    queue_request(OP_REMOVE, 7'd0, NULL_IDX, res);
    queue_request(OP_REMOVE, 7'd0, IDX_MAX, res);
    queue_request(OP_REMOVE, 7'd0, 7'd40, res);
    // Remove from the middle, then the head, then clear what is left.
    queue_request(OP_REMOVE, 7'd0, 7'd1, res);
    queue_request(OP_REMOVE, 7'd0, 7'd0, res);
    queue_request(OP_CLEAR, 7'd2, rand_idx(), res);
    queue_request(OP_CLEAR, NULL_IDX, IDX_MAX, res);
    queue_request(OP_CLEAR, IDX_MAX, '0, res);
    queue_request(OP_ALLOC, rand_idx(), rand_idx(), res);
    for (logic [OP_W:0] c = OP_UNUSED_FIRST; c <= OP_UNUSED_LAST; c++) begin
      queue_request(c[OP_W-1:0], IDX_MAX, IDX_MAX, res);
    end
    queue_request(OP_INIT, IDX_MAX, IDX_MAX, res);
    foreach (list_heads[i]) list_heads[i] = NULL_IDX;

    // Random part: phases of list traffic with some noise mixed in.
    while (pending_requests.size() < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        // One list fills the whole pool, then is taken apart.
        queue_request(OP_INIT, rand_idx(), rand_idx(), res);
        foreach (list_heads[i]) list_heads[i] = NULL_IDX;
        fresh = '0;
        while (fresh != NULL_IDX) begin
          queue_request(OP_ALLOC, rand_idx(), rand_idx(), res);
          fresh = res.index;
          queue_request(OP_APPEND, list_heads[0], fresh, res);
          list_heads[0] = res.index;
        end
        len = list_length(list_heads[0]);
        queue_request(OP_REMOVE, list_heads[0], member_at(list_heads[0], len - 1), res);
        queue_request(OP_REMOVE, list_heads[0], member_at(list_heads[0], 1), res);
        queue_request(OP_ALLOC, rand_idx(), rand_idx(), res);
        fresh = res.index;
        queue_request(OP_APPEND, list_heads[0], fresh, res);
        queue_request(OP_REMOVE, list_heads[0], list_heads[0], res);
        list_heads[0] = res.index;
        queue_request(OP_CLEAR, list_heads[0], rand_idx(), res);
        list_heads[0] = NULL_IDX;
      end else begin
        growing = $urandom_range(0, 1);
        repeat (60) begin
          k = $urandom_range(0, LISTS - 1);
          roll = $urandom_range(0, 99);
          if (roll < 10) begin
            // Noise: any op code with arbitrary fields.
            head = $urandom_range(0, 1) ? list_heads[k] : rand_idx();
            queue_request(OP_W'($urandom_range(0, 7)), head, rand_idx(), res);
            if (pending_requests[$].op == OP_INIT) begin
              foreach (list_heads[i]) list_heads[i] = NULL_IDX;
            end else if (head == list_heads[k]) begin
              if (pending_requests[$].op inside {OP_REMOVE, OP_APPEND})
                list_heads[k] = res.index;
              else if (pending_requests[$].op == OP_CLEAR)
                list_heads[k] = NULL_IDX;
            end
          end else if (roll < (growing ? 73 : 41)) begin
            queue_request(OP_ALLOC, rand_idx(), rand_idx(), res);
            fresh = res.index;
            queue_request(OP_APPEND, list_heads[k], fresh, res);
            list_heads[k] = res.index;
          end else if (roll < 91) begin
            len = list_length(list_heads[k]);
            pick = $urandom_range(0, 99);
            if (len > 0 && pick < 85)
              elem = member_at(list_heads[k], $urandom_range(0, len - 1));
            else if (pick < 95)
              elem = idx_t'($urandom_range(0, NODE_COUNT - 1));
            else
              elem = idx_t'($urandom_range(NODE_COUNT, IDX_MAX));
            queue_request(OP_REMOVE, list_heads[k], elem, res);
            list_heads[k] = res.index;
          end else begin
            queue_request(OP_CLEAR, list_heads[k], rand_idx(), res);
            list_heads[k] = NULL_IDX;
          end
        end
      end
    end

    // Drain: every item accepted and every prediction consumed.
    @(posedge rst_ni);
    while (pending_requests.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (NODE_COUNT + 8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
